>>> hw/rtl/cosine_min_distance_assert.svh
// Assertion macros for the cosine minimum distance block.
// Used by the top level only; needs clk and rst_n in scope.
`ifndef COSINE_MIN_DISTANCE_ASSERT_SVH
`define COSINE_MIN_DISTANCE_ASSERT_SVH

`define CMD_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("label failed");

`define CMD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("label failed");

`endif

>>> hw/rtl/cmd_pkg.sv
// Shared types and constants for the cosine minimum distance block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package cmd_pkg;
    localparam int VecLenDefault = 512;
    localparam int ElemW   = 16;
    localparam int EnergyW = 40;
    localparam int CrossW  = 41;
    localparam int SimW    = 17;
    localparam int RootW   = 31;
    localparam int ProdW   = 62;
    localparam logic [SimW-1:0] SimOne = 17'h10000;

    typedef struct packed {
        logic accumulate;
        logic close_vec;
        logic sqrt_start;
        logic sqrt_step;
        logic mul_step;
        logic div_start;
        logic div_step;
        logic finish;
        logic emit_list;
    } cmd_ctrl_t;

    typedef struct packed {
        logic skip;
        logic list_flag;
    } cmd_stat_t;
endpackage
`default_nettype wire

>>> hw/rtl/cosine_min_distance.sv
// A list-closing transfer gives its result once the square roots, multiply and divide
// are done; the divide is skipped when the closing vector cannot raise the maximum
// (32-step roots, multiply, 16-step divide). Throughput: one element pair per cycle in a
// vector; a closing transfer holds the input through that work, as does a waiting result.
// Reset clears accumulators, the running maximum and the output register.
// Depends on cmd_pkg, cmd_ctrl, cmd_datapath and the assertion header.
`timescale 1ns / 1ps
`default_nettype none
`include "cosine_min_distance_assert.svh"
module cosine_min_distance (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire logic signed [cmd_pkg::ElemW-1:0] query_elem,
    input  wire logic signed [cmd_pkg::ElemW-1:0] track_elem,
    input  wire logic vector_end,
    input  wire logic list_end,
    output logic      out_valid,
    input  wire logic out_ready,
    output logic [cmd_pkg::SimW-1:0] distance
);
    cmd_pkg::cmd_ctrl_t ctrl;
    cmd_pkg::cmd_stat_t stat;
    logic [cmd_pkg::SimW-1:0] result;
    logic out_valid_reg;
    logic [cmd_pkg::SimW-1:0] distance_reg;

    cmd_ctrl u_ctrl (
        .clk, .rst_n, .in_valid, .in_ready, .vector_end, .list_end,
        .out_busy(out_valid_reg && !out_ready),
        .stat, .ctrl
    );

    cmd_datapath u_dp (
        .clk, .rst_n, .ctrl, .query_elem, .track_elem, .list_end, .stat, .result
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            distance_reg <= '0;
        end
        else if (ctrl.emit_list)
        begin
            out_valid_reg <= 1'b1;
            distance_reg <= result;
        end
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    assign out_valid = out_valid_reg;
    assign distance = distance_reg;

    `CMD_ASSERT_IMPL(a_range, out_valid, distance <= cmd_pkg::SimOne)
    `CMD_ASSERT_IMPL(a_no_ready_busy, !in_ready, !(in_valid && in_ready))
    `CMD_ASSERT_NEXT(a_emit_valid, ctrl.emit_list, out_valid)
    `CMD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(distance))
endmodule
`default_nettype wire

>>> hw/rtl/cmd_ctrl.sv
// Controller state machine for the cosine minimum distance block.
// Depends on cmd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cmd_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              vector_end,
    input  wire logic              list_end,
    input  wire logic              out_busy,
    input  wire cmd_pkg::cmd_stat_t stat,
    output cmd_pkg::cmd_ctrl_t     ctrl
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SQRT = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic       fire;

    assign in_ready = (state_reg == S_IDLE) && !out_busy;
    assign fire = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        ctrl = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (fire)
                begin
                    ctrl.accumulate = 1'b1;
                    if (vector_end || list_end)
                    begin
                        ctrl.close_vec = 1'b1;
                        ctrl.sqrt_start = 1'b1;
                        state_next = S_SQRT;
                        cnt_next = '0;
                    end
                end
            end
            S_SQRT:
            begin
                ctrl.sqrt_step = 1'b1;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    state_next = S_MUL;
                    cnt_next = '0;
                end
            end
            S_MUL:
            begin
                ctrl.mul_step = 1'b1;
                state_next = stat.skip ? S_FIN : S_DIV;
                cnt_next = '0;
            end
            S_DIV:
            begin
                if (cnt_reg == 5'd0)
                begin
                    ctrl.div_start = 1'b1;
                    cnt_next = 5'd1;
                end
                else
                begin
                    ctrl.div_step = 1'b1;
                    cnt_next = cnt_reg + 5'd1;
                    if (cnt_reg == 5'd16)
                    begin
                        state_next = S_FIN;
                        cnt_next = '0;
                    end
                end
            end
            S_FIN:
            begin
                ctrl.finish = 1'b1;
                ctrl.emit_list = stat.list_flag;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
        end
    end
endmodule
`default_nettype wire

>>> hw/rtl/cmd_datapath.sv
// Datapath: accumulators, two square roots run side by side, multiplier and divider.
// Depends on cmd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cmd_datapath (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire cmd_pkg::cmd_ctrl_t          ctrl,
    input  wire logic signed [cmd_pkg::ElemW-1:0] query_elem,
    input  wire logic signed [cmd_pkg::ElemW-1:0] track_elem,
    input  wire logic                        list_end,
    output cmd_pkg::cmd_stat_t               stat,
    output logic [cmd_pkg::SimW-1:0]         result
);
    localparam int EW = cmd_pkg::EnergyW;
    localparam int CW = cmd_pkg::CrossW;
    localparam int RW = cmd_pkg::RootW;
    localparam int PW = cmd_pkg::ProdW;
    localparam int SW = cmd_pkg::SimW;

    logic [EW-1:0] qe_reg, te_reg, qe_h_reg, te_h_reg;
    logic signed [CW-1:0] cs_reg, cs_h_reg;
    logic [SW-1:0] best_reg;
    logic list_reg;
    logic [63:0] qv_reg, tv_reg;
    logic [63:0] qroot_reg, troot_reg;
    logic [63:0] sbit_reg;
    logic [PW-1:0] d_reg;
    logic [PW:0] r_reg;
    logic [15:0] q_reg;
    logic sat_reg;

    logic signed [31:0] qx, tx;
    logic [31:0] pa, pb;
    logic signed [31:0] pc;
    logic [EW:0] qe_sum, te_sum;
    logic signed [CW:0] cs_sum;
    logic [EW-1:0] qe_new, te_new;
    logic signed [CW-1:0] cs_new;
    logic [64:0] q_trial, t_trial;
    logic [RW-1:0] rq, rt;
    logic [PW-1:0] d_prod;
    logic [PW:0] r_init, r_sh;
    logic [SW-1:0] sim;
    logic [SW-1:0] best_upd;

    assign qx = 32'(query_elem);
    assign tx = 32'(track_elem);
    assign pa = $unsigned(qx * qx);
    assign pb = $unsigned(tx * tx);
    assign pc = qx * tx;
    assign qe_sum = {1'b0, qe_reg} + {{(EW+1-32){1'b0}}, pa};
    assign te_sum = {1'b0, te_reg} + {{(EW+1-32){1'b0}}, pb};
    assign cs_sum = {cs_reg[CW-1], cs_reg} + (CW+1)'(pc);
    assign qe_new = qe_sum[EW] ? {EW{1'b1}} : qe_sum[EW-1:0];
    assign te_new = te_sum[EW] ? {EW{1'b1}} : te_sum[EW-1:0];
    always_comb
    begin
        if (cs_sum[CW] != cs_sum[CW-1])
            cs_new = cs_sum[CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
        else
            cs_new = cs_sum[CW-1:0];
    end

    assign q_trial = {1'b0, qv_reg} - ({1'b0, qroot_reg} + {1'b0, sbit_reg});
    assign t_trial = {1'b0, tv_reg} - ({1'b0, troot_reg} + {1'b0, sbit_reg});
    assign rq = qroot_reg[RW-1:0];
    assign rt = troot_reg[RW-1:0];
    assign d_prod = PW'(rq) * PW'(rt);
    assign r_init = {1'b0, cs_h_reg[CW-2:0], 22'b0};
    assign r_sh = {r_reg[PW-1:0], 1'b0};

    assign stat.skip = (qe_h_reg == '0) || (te_h_reg == '0) || (cs_h_reg <= 0);
    assign stat.list_flag = list_reg;
    assign sim = sat_reg ? cmd_pkg::SimOne : {1'b0, q_reg};
    assign best_upd = (!stat.skip && sim > best_reg) ? sim : best_reg;
    assign result = cmd_pkg::SimOne - best_upd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qe_reg <= '0;
            te_reg <= '0;
            cs_reg <= '0;
            best_reg <= '0;
            list_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.accumulate)
            begin
                if (ctrl.close_vec)
                begin
                    qe_reg <= '0;
                    te_reg <= '0;
                    cs_reg <= '0;
                    list_reg <= list_end;
                end
                else
                begin
                    qe_reg <= qe_new;
                    te_reg <= te_new;
                    cs_reg <= cs_new;
                end
            end
            if (ctrl.finish)
            begin
                if (ctrl.emit_list)
                    best_reg <= '0;
                else
                    best_reg <= best_upd;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.accumulate && ctrl.close_vec)
        begin
            qe_h_reg <= qe_new;
            te_h_reg <= te_new;
            cs_h_reg <= cs_new;
        end
        if (ctrl.sqrt_start)
        begin
            qv_reg <= {2'b0, qe_new, 22'b0};
            tv_reg <= {2'b0, te_new, 22'b0};
            qroot_reg <= '0;
            troot_reg <= '0;
            sbit_reg <= 64'h4000_0000_0000_0000;
        end
        else if (ctrl.sqrt_step)
        begin
            if (!q_trial[64])
            begin
                qv_reg <= q_trial[63:0];
                qroot_reg <= (qroot_reg >> 1) + sbit_reg;
            end
            else
                qroot_reg <= qroot_reg >> 1;
            if (!t_trial[64])
            begin
                tv_reg <= t_trial[63:0];
                troot_reg <= (troot_reg >> 1) + sbit_reg;
            end
            else
                troot_reg <= troot_reg >> 1;
            sbit_reg <= sbit_reg >> 2;
        end
        if (ctrl.mul_step)
            d_reg <= d_prod;
        if (ctrl.div_start)
        begin
            r_reg <= r_init;
            sat_reg <= r_init >= {1'b0, d_reg};
            q_reg <= '0;
        end
        else if (ctrl.div_step)
        begin
            if (r_sh >= {1'b0, d_reg})
            begin
                r_reg <= r_sh - {1'b0, d_reg};
                q_reg <= {q_reg[14:0], 1'b1};
            end
            else
            begin
                r_reg <= r_sh;
                q_reg <= {q_reg[14:0], 1'b0};
            end
        end
    end
endmodule
`default_nettype wire
